// ===== rtl/osf_pkg.sv =====
`default_nettype none

package osf_pkg;

    // Observer size and the layout of the coefficient table.
    localparam int STATE_N     = 3;
    localparam int COEFF_DEPTH = STATE_N * STATE_N + 3 * STATE_N - 1;
    localparam int G_BASE      = STATE_N * STATE_N;
    localparam int H_BASE      = STATE_N * STATE_N + STATE_N;
    localparam int K_BASE      = STATE_N * STATE_N + 2 * STATE_N;

    // Index and counter widths.
    localparam int CI_W  = $clog2(COEFF_DEPTH);
    localparam int SI_W  = $clog2(STATE_N);
    localparam int ROW_W = $clog2(STATE_N + 1);
    localparam int COL_W = $clog2(STATE_N + 2);

    // Datapath widths: Q16.16 words, full products, shifted terms, accumulator.
    localparam int Q_W    = 32;
    localparam int PROD_W = 2 * Q_W;
    localparam int ACC_W  = PROD_W - 16 + $clog2(STATE_N + 2) + 1;

    // Request codes of an input word.
    typedef enum logic [1:0] {
        REQ_STEP  = 2'd0,
        REQ_COEFF = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_EST   = 2'd3
    } req_t;

    // Control modes.
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_DIST  = 2'd1;
    localparam logic [1:0] MODE_MEAS  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRUST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } seq_state_t;

    // One multiply-accumulate operation as it travels through the MAC.
    typedef struct packed {
        logic             issue;
        logic             first;
        logic             last;
        logic [ROW_W-1:0] row;
    } mac_op_t;

endpackage

`default_nettype wire

// ===== rtl/osf_mac.sv =====
`default_nettype none

module osf_mac
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire osf_pkg::mac_op_t                   op,
    input  wire logic signed [osf_pkg::Q_W-1:0]     a,
    input  wire logic signed [osf_pkg::Q_W-1:0]     b,
    output osf_pkg::mac_op_t                        done,
    output logic signed [osf_pkg::Q_W-1:0]          result
);

    localparam logic signed [osf_pkg::ACC_W-1:0] SAT_HI = osf_pkg::ACC_W'(2147483647);
    localparam logic signed [osf_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    logic signed [osf_pkg::PROD_W-1:0] prod_reg;
    logic signed [osf_pkg::PROD_W-1:0] prod_shift;
    logic signed [osf_pkg::ACC_W-1:0]  acc_reg;
    logic signed [osf_pkg::ACC_W-1:0]  acc_base;
    logic signed [osf_pkg::ACC_W-1:0]  term;
    logic signed [osf_pkg::ACC_W-1:0]  acc_sum;
    osf_pkg::mac_op_t                  op_reg;

    // Multiplier stage: the full product is registered.
    always_ff @(posedge clk)
    begin
        if (op.issue)
        begin
            prod_reg <= a * b;
        end
    end

    // Operation tag is registered alongside the product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0;
        end
        else
        begin
            op_reg <= op;
        end
    end

    // Drop the low 16 bits (floor) and add into the accumulator.
    always_comb
    begin
        prod_shift = prod_reg >>> 16;
        term       = prod_shift[osf_pkg::ACC_W-1:0];
        acc_base   = op_reg.first ? '0 : acc_reg;
        acc_sum    = acc_base + term;
    end

    always_ff @(posedge clk)
    begin
        if (op_reg.issue)
        begin
            acc_reg <= acc_sum;
        end
    end

    // Saturate the running sum to a 32-bit word.
    always_comb
    begin
        if (acc_sum > SAT_HI)
        begin
            result = SAT_HI[osf_pkg::Q_W-1:0];
        end
        else if (acc_sum < SAT_LO)
        begin
            result = SAT_LO[osf_pkg::Q_W-1:0];
        end
        else
        begin
            result = acc_sum[osf_pkg::Q_W-1:0];
        end
    end

    assign done = op_reg;

endmodule

`default_nettype wire

// ===== rtl/observer_state_feedback.sv =====
`default_nettype none

// A step word runs the N prediction rows and then the feedback sum before out_valid;
// any other word runs only the feedback sum. No new word is taken until the result
// word is loaded. Every product goes through one shared 32x32 multiplier, one term
// per cycle; the count of terms in the rows that a word runs sets how long it takes.
// Reset clears both estimates, the coefficient table and the sequencer, sets
// thrust_limit to its maximum and control_mode to plain feedback.
module observer_state_feedback
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [1:0]                           req_type,
    input  wire logic [4:0]                           coeff_index,
    input  wire logic [1:0]                           state_index,
    input  wire logic signed [31:0]                   load_value,
    input  wire logic signed [31:0]                   drive_in,
    input  wire logic signed [31:0]                   measure_in,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [31:0]                        control_out,
    output logic signed [31:0]                        estimate_first,
    output logic signed [31:0]                        predicted_first,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [osf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [31:0]                          cfg_data
);

    localparam int N  = osf_pkg::STATE_N;
    localparam int QW = osf_pkg::Q_W;

    // Sequencer and item registers.
    osf_pkg::seq_state_t           state_reg, seq_next;
    logic [osf_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [osf_pkg::COL_W-1:0]     col_reg, col_next;
    osf_pkg::req_t                 req_reg;
    logic [4:0]                    ci_reg;
    logic [1:0]                    si_reg;
    logic signed [QW-1:0]          val_reg;
    logic signed [QW-1:0]          u_reg;
    logic signed [QW-1:0]          y_reg;

    // Configuration.
    logic [30:0]                   thrust_reg;
    logic [1:0]                    mode_reg;

    // Observer state.
    logic signed [QW-1:0]          est_now_reg  [N];
    logic signed [QW-1:0]          est_next_reg [N];
    logic signed [QW-1:0]          coeff_reg    [osf_pkg::COEFF_DEPTH];
    logic signed [QW-1:0]          ctrl_sum_reg;

    // Output word.
    logic                          out_valid_reg;
    logic signed [QW-1:0]          control_out_reg;
    logic signed [QW-1:0]          est_first_reg;
    logic signed [QW-1:0]          pred_first_reg;

    // Sequencer outputs and MAC connections.
    logic                          accept;
    logic                          load_out;
    logic                          row_is_ctrl;
    logic                          last_col;
    logic [osf_pkg::CI_W-1:0]      a_idx;
    logic signed [QW-1:0]          mac_a;
    logic signed [QW-1:0]          mac_b;
    osf_pkg::mac_op_t              mac_op;
    osf_pkg::mac_op_t              mac_done;
    logic signed [QW-1:0]          mac_result;

    // Feedback finishing.
    logic signed [QW+1:0]          fb_raw;
    logic signed [QW+1:0]          fb_lim;
    logic signed [QW-1:0]          fb_out;

    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thrust_reg <= '1;
            mode_reg   <= osf_pkg::MODE_PLAIN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                osf_pkg::CFG_THRUST: thrust_reg <= cfg_data[30:0];
                osf_pkg::CFG_MODE:   mode_reg   <= cfg_data[1:0];
                default:             ;
            endcase
        end
    end

    // Capture the input word.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= osf_pkg::req_t'(req_type);
            ci_reg  <= coeff_index;
            si_reg  <= state_index;
            val_reg <= load_value;
            u_reg   <= drive_in;
            y_reg   <= measure_in;
        end
    end

    // Term selection: prediction rows run F, G, H; the last row runs the K gains.
    always_comb
    begin
        row_is_ctrl = (row_reg == osf_pkg::ROW_W'(N));
        if (row_is_ctrl)
        begin
            last_col = (col_reg == osf_pkg::COL_W'(N - 2));
            a_idx    = osf_pkg::CI_W'(osf_pkg::K_BASE) + osf_pkg::CI_W'(col_reg);
        end
        else
        begin
            last_col = (col_reg == osf_pkg::COL_W'(N + 1));
            if (col_reg < osf_pkg::COL_W'(N))
            begin
                a_idx = osf_pkg::CI_W'(row_reg) * osf_pkg::CI_W'(N)
                        + osf_pkg::CI_W'(col_reg);
            end
            else if (col_reg == osf_pkg::COL_W'(N))
            begin
                a_idx = osf_pkg::CI_W'(osf_pkg::G_BASE) + osf_pkg::CI_W'(row_reg);
            end
            else
            begin
                a_idx = osf_pkg::CI_W'(osf_pkg::H_BASE) + osf_pkg::CI_W'(row_reg);
            end
        end
        mac_a = coeff_reg[a_idx];

        if (row_is_ctrl && col_reg == '0 && mode_reg == osf_pkg::MODE_MEAS)
        begin
            mac_b = y_reg;
        end
        else if (!row_is_ctrl && col_reg == osf_pkg::COL_W'(N))
        begin
            mac_b = u_reg;
        end
        else if (!row_is_ctrl && col_reg == osf_pkg::COL_W'(N + 1))
        begin
            mac_b = y_reg;
        end
        else
        begin
            mac_b = est_now_reg[osf_pkg::SI_W'(col_reg)];
        end

        mac_op.issue = (state_reg == osf_pkg::ST_RUN);
        mac_op.first = (col_reg == '0);
        mac_op.last  = last_col;
        mac_op.row   = row_reg;
    end

    osf_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (mac_op),
        .a      (mac_a),
        .b      (mac_b),
        .done   (mac_done),
        .result (mac_result)
    );

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= osf_pkg::ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= seq_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    // Sequencer next state.
    always_comb
    begin
        seq_next   = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        in_stall   = 1'b1;
        load_out   = 1'b0;
        unique case (state_reg)
            osf_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    seq_next = osf_pkg::ST_APPLY;
                end
            end
            osf_pkg::ST_APPLY:
            begin
                row_next = (req_reg == osf_pkg::REQ_STEP) ? '0 : osf_pkg::ROW_W'(N);
                col_next = '0;
                seq_next = osf_pkg::ST_RUN;
            end
            osf_pkg::ST_RUN:
            begin
                if (last_col)
                begin
                    col_next = '0;
                    if (row_is_ctrl)
                    begin
                        seq_next = osf_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            osf_pkg::ST_DRAIN:
            begin
                seq_next = osf_pkg::ST_FINISH;
            end
            osf_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out = 1'b1;
                    seq_next = osf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                seq_next = osf_pkg::ST_IDLE;
            end
        endcase
    end

    // Estimates and coefficient table: item effects and finished prediction rows.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < N; i++)
            begin
                est_now_reg[i]  <= '0;
                est_next_reg[i] <= '0;
            end
            for (int i = 0; i < osf_pkg::COEFF_DEPTH; i++)
            begin
                coeff_reg[i] <= '0;
            end
        end
        else
        begin
            if (state_reg == osf_pkg::ST_APPLY)
            begin
                unique case (req_reg)
                    osf_pkg::REQ_STEP:
                    begin
                        for (int i = 0; i < N; i++)
                        begin
                            est_now_reg[i] <= est_next_reg[i];
                        end
                    end
                    osf_pkg::REQ_COEFF:
                    begin
                        if (ci_reg < osf_pkg::COEFF_DEPTH)
                        begin
                            coeff_reg[osf_pkg::CI_W'(ci_reg)] <= val_reg;
                        end
                    end
                    osf_pkg::REQ_INIT:
                    begin
                        for (int i = 1; i < N; i++)
                        begin
                            est_now_reg[i]  <= '0;
                            est_next_reg[i] <= '0;
                        end
                        est_now_reg[0]  <= y_reg;
                        est_next_reg[0] <= y_reg;
                    end
                    osf_pkg::REQ_EST:
                    begin
                        if (si_reg < N)
                        begin
                            est_now_reg[osf_pkg::SI_W'(si_reg)]  <= val_reg;
                            est_next_reg[osf_pkg::SI_W'(si_reg)] <= val_reg;
                        end
                    end
                    default: ;
                endcase
            end
            if (mac_done.issue && mac_done.last && mac_done.row < osf_pkg::ROW_W'(N))
            begin
                est_next_reg[osf_pkg::SI_W'(mac_done.row)] <= mac_result;
            end
        end
    end

    // The feedback sum lands when the last gain term leaves the MAC.
    always_ff @(posedge clk)
    begin
        if (mac_done.issue && mac_done.last && mac_done.row == osf_pkg::ROW_W'(N))
        begin
            ctrl_sum_reg <= mac_result;
        end
    end

    // Negate, optionally reject the disturbance state, then clamp to the thrust limit.
    always_comb
    begin
        fb_raw = -(QW + 2)'(ctrl_sum_reg);
        if (mode_reg == osf_pkg::MODE_DIST)
        begin
            fb_raw = fb_raw - (QW + 2)'(est_now_reg[2]);
        end
        fb_lim = $signed({3'b000, thrust_reg});
        if (fb_raw > fb_lim)
        begin
            fb_out = fb_lim[QW-1:0];
        end
        else if (fb_raw < -fb_lim)
        begin
            fb_out = -fb_lim[QW-1:0];
        end
        else
        begin
            fb_out = fb_raw[QW-1:0];
        end
    end

    // Output word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            control_out_reg <= fb_out;
            est_first_reg   <= est_now_reg[0];
            pred_first_reg  <= est_next_reg[0];
        end
    end

    assign out_valid       = out_valid_reg;
    assign control_out     = control_out_reg;
    assign estimate_first  = est_first_reg;
    assign predicted_first = pred_first_reg;

    // A finished MAC operation only appears while a word is being worked.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_done.issue |-> (state_reg == osf_pkg::ST_RUN || state_reg == osf_pkg::ST_DRAIN))
        else $error("MAC result outside of a running item");

    // No product is still in flight when the result word is formed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == osf_pkg::ST_FINISH) |-> !mac_done.issue)
        else $error("MAC still busy at finish");

    // A new control value never exceeds the thrust limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |->
            (control_out_reg <= $signed({1'b0, thrust_reg})
             && control_out_reg >= -$signed({1'b0, thrust_reg})))
        else $error("control value beyond thrust limit");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // Expected contents of one result word.
    typedef struct {
        logic signed [31:0] control;
        logic signed [31:0] est_first;
        logic signed [31:0] pred_first;
    } obs_word_t;

    // Codes with no name in the package.
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [osf_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [osf_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Saturation bounds of a Q16.16 word, and spans for random values.
    localparam logic signed [71:0] Q_TOP = 72'sh7FFF_FFFF;
    localparam logic signed [71:0] Q_BOT = -72'sh8000_0000;
    localparam logic [31:0] GAIN_SPAN = 32'h0001_0000;
    localparam logic [31:0] SIG_SPAN  = 32'h0004_0000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] req_type;
    logic [4:0] coeff_index;
    logic [1:0] state_index;
    logic signed [31:0] load_value;
    logic signed [31:0] drive_in;
    logic signed [31:0] measure_in;
    logic out_valid;
    logic out_stall;
    logic signed [31:0] control_out;
    logic signed [31:0] estimate_first;
    logic signed [31:0] predicted_first;
    logic cfg_valid;
    logic cfg_ready;
    logic [osf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    // Own copy of the observer state and registers, in their reset values.
    logic signed [31:0] est_now [osf_pkg::STATE_N] = '{default: '0};
    logic signed [31:0] est_next [osf_pkg::STATE_N] = '{default: '0};
    logic signed [31:0] coeffs [osf_pkg::COEFF_DEPTH] = '{default: '0};
    logic [30:0] thrust_cap = '1;
    logic [1:0] mode_reg = osf_pkg::MODE_PLAIN;

    obs_word_t outputs_due[$];
    int error_count = 0;
    bit calm = 1'b0;

    observer_state_feedback uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .req_type(req_type),
        .coeff_index(coeff_index),
        .state_index(state_index),
        .load_value(load_value),
        .drive_in(drive_in),
        .measure_in(measure_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .control_out(control_out),
        .estimate_first(estimate_first),
        .predicted_first(predicted_first),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Q16.16 product, low 16 bits dropped (rounds toward minus infinity).
    function automatic logic signed [71:0] q_product(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p >>> 16;
    endfunction

    function automatic logic signed [31:0] sat_q(input logic signed [71:0] v);
        if (v > Q_TOP)
            return 32'sh7FFF_FFFF;
        if (v < Q_BOT)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Applies one accepted word to the observer copy and returns its result word.
    function automatic obs_word_t advance_observer(input logic [1:0] req,
                                                   input logic [4:0] ci,
                                                   input logic [1:0] si,
                                                   input logic signed [31:0] val,
                                                   input logic signed [31:0] u,
                                                   input logic signed [31:0] y);
        logic signed [31:0] fresh [osf_pkg::STATE_N];
        logic signed [71:0] acc;
        logic signed [71:0] lim;
        logic signed [31:0] xj;
        obs_word_t r;
        case (req)
            osf_pkg::REQ_STEP:
            begin
                est_now = est_next;
                for (int i = 0; i < osf_pkg::STATE_N; i++)
                begin
                    acc = '0;
                    for (int j = 0; j < osf_pkg::STATE_N; j++)
                        acc += q_product(coeffs[i * osf_pkg::STATE_N + j], est_now[j]);
                    acc += q_product(coeffs[osf_pkg::G_BASE + i], u);
                    acc += q_product(coeffs[osf_pkg::H_BASE + i], y);
                    fresh[i] = sat_q(acc);
                end
                est_next = fresh;
            end
            osf_pkg::REQ_COEFF:
            begin
                if (ci < osf_pkg::COEFF_DEPTH)
                    coeffs[ci] = val;
            end
            osf_pkg::REQ_INIT:
            begin
                for (int i = 0; i < osf_pkg::STATE_N; i++)
                begin
                    est_now[i] = '0;
                    est_next[i] = '0;
                end
                est_now[0] = y;
                est_next[0] = y;
            end
            default:
            begin
                if (si < osf_pkg::STATE_N)
                begin
                    est_now[si] = val;
                    est_next[si] = val;
                end
            end
        endcase

        // Feedback over the first N-1 states; the mode code 3 behaves as plain.
        acc = '0;
        for (int j = 0; j < osf_pkg::STATE_N - 1; j++)
        begin
            xj = (j == 0 && mode_reg == osf_pkg::MODE_MEAS) ? y : est_now[j];
            acc += q_product(coeffs[osf_pkg::K_BASE + j], xj);
        end
        acc = sat_q(acc);
        acc = -acc;
        if (mode_reg == osf_pkg::MODE_DIST)
            acc = acc - est_now[2];
        lim = thrust_cap;
        if (acc > lim)
            acc = lim;
        else if (acc < -lim)
            acc = -lim;

        r.control = acc[31:0];
        r.est_first = est_now[0];
        r.pred_first = est_next[0];
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Q16.16 value: mostly within +/- span, sometimes an extreme or any word.
    function automatic logic [31:0] rand_q(input logic [31:0] span);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // Sends one input word after a random gap; valid stays high across back-to-back words.
    task automatic send_word(input osf_pkg::req_t req, input logic [4:0] ci,
                             input logic [1:0] si, input logic [31:0] val,
                             input logic [31:0] u, input logic [31:0] y);
        int gap;
        obs_word_t due;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        coeff_index <= ci;
        state_index <= si;
        load_value <= val;
        drive_in <= u;
        measure_in <= y;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        due = advance_observer(req, ci, si, val, u, y);
        outputs_due.insert(outputs_due.size(), due);
    endtask

    // Holds the sender until every expected word is back, then lets the block settle.
    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (outputs_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [osf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (idx == osf_pkg::CFG_THRUST)
            thrust_cap = data[30:0];
        else if (idx == osf_pkg::CFG_MODE)
            mode_reg = data[1:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Fresh block: zero estimates and table, and an out-of-range estimate write.
    task automatic test_after_reset();
        send_word(osf_pkg::REQ_STEP, 5'd0, 2'd0, 32'd0, 32'h0001_0000, 32'h0002_0000);
        send_word(osf_pkg::REQ_EST, 5'd0, 2'd3, 32'h1234_5678, 32'd0, 32'd0);
    endtask

    // Extreme coefficients and estimates, slots past the table, and saturating steps.
    task automatic test_table_extremes();
        send_word(osf_pkg::REQ_COEFF, 5'd0, 2'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
        send_word(osf_pkg::REQ_COEFF, 5'd4, 2'd0, 32'h8000_0000, 32'd0, 32'd0);
        send_word(osf_pkg::REQ_COEFF, 5'(osf_pkg::G_BASE), 2'd0, 32'h8000_0000,
                  32'd0, 32'd0);
        send_word(osf_pkg::REQ_COEFF, 5'(osf_pkg::H_BASE + 2), 2'd0, 32'h7FFF_FFFF,
                  32'd0, 32'd0);
        send_word(osf_pkg::REQ_COEFF, 5'(osf_pkg::K_BASE), 2'd0, 32'h0002_0000,
                  32'd0, 32'd0);
        send_word(osf_pkg::REQ_COEFF, 5'(osf_pkg::K_BASE + 1), 2'd0, 32'h8000_0000,
                  32'd0, 32'd0);
        send_word(osf_pkg::REQ_COEFF, 5'(osf_pkg::COEFF_DEPTH), 2'd0, 32'h7FFF_FFFF,
                  32'd0, 32'd0);
        send_word(osf_pkg::REQ_COEFF, 5'd31, 2'd3, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_word(osf_pkg::REQ_EST, 5'd0, 2'd0, 32'h7FFF_FFFF, 32'd0, 32'd0);
        send_word(osf_pkg::REQ_EST, 5'd0, 2'd1, 32'h8000_0000, 32'd0, 32'd0);
        send_word(osf_pkg::REQ_EST, 5'd0, 2'd2, 32'h8000_0000, 32'd0, 32'd0);
        send_word(osf_pkg::REQ_STEP, 5'd0, 2'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(osf_pkg::REQ_STEP, 5'd0, 2'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(osf_pkg::REQ_INIT, 5'd0, 2'd0, 32'd0, 32'd0, 32'h8000_0000);
        send_word(osf_pkg::REQ_STEP, 5'd0, 2'd0, 32'd0, 32'h0001_0000, 32'hFFFF_0000);
    endtask

    // Each control mode, including the unused code, and thrust bounds at their extremes.
    task automatic test_modes_and_limits();
        wait_drained(4);
        write_reg(osf_pkg::CFG_MODE, {30'd0, osf_pkg::MODE_DIST});
        send_word(osf_pkg::REQ_EST, 5'd0, 2'd2, 32'h7FFF_FFFF, 32'd0, 32'd0);
        wait_drained(4);
        write_reg(osf_pkg::CFG_MODE, {30'd0, osf_pkg::MODE_MEAS});
        send_word(osf_pkg::REQ_STEP, 5'd0, 2'd0, 32'd0, 32'd0, 32'h8000_0000);
        wait_drained(4);
        write_reg(osf_pkg::CFG_MODE, {30'd0, MODE_SPARE});
        send_word(osf_pkg::REQ_INIT, 5'd0, 2'd0, 32'd0, 32'd0, 32'h0003_0000);
        wait_drained(4);
        write_reg(osf_pkg::CFG_MODE, {30'd0, osf_pkg::MODE_PLAIN});
        write_reg(osf_pkg::CFG_THRUST, 32'd0);
        send_word(osf_pkg::REQ_STEP, 5'd0, 2'd0, 32'd0, 32'h0001_0000, 32'h0005_0000);
        wait_drained(4);
        write_reg(osf_pkg::CFG_THRUST, 32'd1);
        send_word(osf_pkg::REQ_INIT, 5'd0, 2'd0, 32'd0, 32'd0, 32'hFFF0_0000);
        wait_drained(4);
        write_reg(osf_pkg::CFG_THRUST, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_A, 32'h0000_0001);
        send_word(osf_pkg::REQ_INIT, 5'd0, 2'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
    endtask

    // Phases of well-formed runs (table reload, start estimate, steps) with noise mixed in,
    // each phase under a new register setting taken while the block is idle.
    task automatic test_random_traffic();
        logic [31:0] data;
        int n_steps;
        for (int phase = 0; phase < 15; phase++)
        begin
            calm = (phase == 6);
            wait_drained(4);

            data = $urandom();
            case ($urandom_range(0, 4))
                0: data[30:0] = '0;
                1: data[30:0] = 31'd1;
                2: data[30:0] = '1;
                3: data[30:0] = $urandom_range(0, 32'h000F_FFFF);
                default: ;
            endcase
            write_reg(osf_pkg::CFG_THRUST, data);
            write_reg(osf_pkg::CFG_MODE, $urandom());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());

            // Reload the whole table first, then a random part of it.
            for (int slot = 0; slot < osf_pkg::COEFF_DEPTH; slot++)
                if (phase == 0 || $urandom_range(0, 1) == 0)
                    send_word(osf_pkg::REQ_COEFF, 5'(slot), 2'($urandom()),
                              rand_q(GAIN_SPAN), $urandom(), $urandom());

            // Start from a measurement or from written elements.
            if ($urandom_range(0, 1) == 0)
                send_word(osf_pkg::REQ_INIT, 5'($urandom()), 2'($urandom()), $urandom(),
                          $urandom(), rand_q(SIG_SPAN));
            else
                for (int k = 0; k < osf_pkg::STATE_N; k++)
                    send_word(osf_pkg::REQ_EST, 5'($urandom()), 2'(k), rand_q(SIG_SPAN),
                              $urandom(), $urandom());

            n_steps = $urandom_range(14, 22);
            for (int k = 0; k < n_steps; k++)
                if ($urandom_range(0, 6) == 0)
                    send_word(osf_pkg::req_t'($urandom_range(0, 3)), 5'($urandom()),
                              2'($urandom()), $urandom(), $urandom(), $urandom());
                else
                    send_word(osf_pkg::REQ_STEP, 5'($urandom()), 2'($urandom()),
                              $urandom(), rand_q(SIG_SPAN), rand_q(SIG_SPAN));
        end
        calm = 1'b0;
    endtask

    // Receiver stalls in bursts, released during calm stretches.
    initial
    begin
        int n;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            n = idle_len();
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Each accepted result word against the oldest outstanding expectation.
    always @(posedge clk)
    begin : check_outputs
        obs_word_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (outputs_due.size() == 0)
            begin
                $error("result word with nothing outstanding: control_out %0d", control_out);
                error_count++;
            end
            else
            begin
                want = outputs_due.pop_front();
                check_field("control_out", want.control, control_out);
                check_field("estimate_first", want.est_first, estimate_first);
                check_field("predicted_first", want.pred_first, predicted_first);
            end
        end
    end

    // Sequence of tests.
    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        req_type <= osf_pkg::REQ_STEP;
        coeff_index <= '0;
        state_index <= '0;
        load_value <= '0;
        drive_in <= '0;
        measure_in <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= osf_pkg::CFG_THRUST;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_table_extremes();
        test_modes_and_limits();
        test_random_traffic();

        wait_drained(30);
        if (error_count == 0 && outputs_due.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
